// ===== rtl/apt_pkg.sv =====
// Shared types and constants for the all-pairs proximity test block.
// Holds the command and result word layouts and the request codes.
// No dependencies.
package apt_pkg;

  // Width of one coordinate, fixed by the command word layout.
  localparam int COORD_BITS = 16;
  // Coordinates carried by one command word.
  localparam int COORD_FIELDS = 7;
  // Width of the stored-count field in the result word.
  localparam int COUNT_BITS = 9;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]                   req_type;
    logic signed [COORD_BITS-1:0] coord_0;
    logic signed [COORD_BITS-1:0] coord_1;
    logic signed [COORD_BITS-1:0] coord_2;
    logic signed [COORD_BITS-1:0] coord_3;
    logic signed [COORD_BITS-1:0] coord_4;
    logic signed [COORD_BITS-1:0] coord_5;
    logic signed [COORD_BITS-1:0] coord_6;
  } apt_cmd_t;

  typedef struct packed {
    logic                  point_hit;
    logic                  any_hit;
    logic [COUNT_BITS-1:0] stored_count;
    logic                  overflow;
  } apt_result_t;

endpackage

// ===== rtl/all_pairs_proximity_test_7d.sv =====
// Top level of the all-pairs proximity test: point store, sequencer and the
// shared subtract, square and accumulate unit.
// Depends on apt_pkg.
//
//   channel   direction  handshake               payload
//   command   in         start, busy             cmd (apt_cmd_t)
//   result    out        done strobe, no stall   result (apt_result_t)
//   config    in         cfg_valid, cfg_ready    cfg_data (threshold, Q8.8)
//
// A command word is taken when start is high and busy is low; busy stays high
// until the result word has been set up. A query squares and sums the differences
// over the first min(DIMENSIONS, 7) coordinates of every stored point: the one
// multiplier squares one coordinate difference per cycle, fed from a single
// memory read port. Each result word is shown for one cycle with done and
// cannot be held off. Reset clears the count and both flags; the store itself
// is not cleared.
module all_pairs_proximity_test_7d
  import apt_pkg::*;
#(
  parameter int MAX_POINTS = 256,
  parameter int DIMENSIONS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  apt_cmd_t    cmd,
  output logic        done,
  output apt_result_t result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int UDIMS  = (DIMENSIONS < COORD_FIELDS) ? DIMENSIONS : COORD_FIELDS;
  localparam int DEPTH  = MAX_POINTS * UDIMS;
  localparam int ADDR_W = $clog2(DEPTH + 1);
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int DIM_W  = (UDIMS > 1) ? $clog2(UDIMS) : 1;
  localparam int MAG_W  = COORD_BITS;
  localparam int TERM_W = 2 * MAG_W;
  localparam int SUM_W  = TERM_W + 3;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_LIM  = 3'd2;
  localparam logic [2:0] S_LIM2 = 3'd3;
  localparam logic [2:0] S_RUN  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]             state;
  logic [15:0]            threshold;
  logic [CNT_W-1:0]       count;
  logic [ADDR_W-1:0]      fill_addr;
  logic [ADDR_W-1:0]      rd_addr;
  logic [DIM_W-1:0]       dim_cnt;
  logic                   sticky_hit;
  logic                   overflow_flag;
  logic                   qhit;
  logic [TERM_W-1:0]      lim;
  logic [SUM_W-1:0]       acc;
  logic [TERM_W-1:0]      term;

  logic signed [COORD_BITS-1:0] pt_reg  [UDIMS];
  logic signed [COORD_BITS-1:0] in_coord [COORD_FIELDS];
  logic signed [COORD_BITS-1:0] mem [DEPTH];
  logic signed [COORD_BITS-1:0] rd_data;

  logic s1_valid, s1_last_dim, s1_last;
  logic s2_valid, s2_last_dim, s2_last;

  logic                   accept;
  logic                   issue;
  logic                   last_dim;
  logic                   rotate;
  logic signed [COORD_BITS:0] diff;
  logic [MAG_W-1:0]       mag;
  logic [MAG_W-1:0]       mul_a;
  logic [SUM_W-1:0]       sum_next;
  logic [31:0]            count32;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign in_coord[0] = cmd.coord_0;
  assign in_coord[1] = cmd.coord_1;
  assign in_coord[2] = cmd.coord_2;
  assign in_coord[3] = cmd.coord_3;
  assign in_coord[4] = cmd.coord_4;
  assign in_coord[5] = cmd.coord_5;
  assign in_coord[6] = cmd.coord_6;

  assign issue    = (state == S_RUN) && (rd_addr != fill_addr);
  assign last_dim = (dim_cnt == DIM_W'(UDIMS - 1));
  // The point register rotates so that the coordinate in use is always at the front.
  assign rotate   = (state == S_LOAD) || s1_valid;

  // Shared unit: one absolute difference squared per cycle. The same
  // multiplier squares the threshold at the start of a query.
  always_comb begin
    diff  = {rd_data[COORD_BITS-1], rd_data} - {pt_reg[0][COORD_BITS-1], pt_reg[0]};
    mag   = diff[COORD_BITS] ? MAG_W'(-diff) : diff[MAG_W-1:0];
    mul_a = (state == S_LIM) ? threshold : mag;
    sum_next = acc + SUM_W'(term);
  end

  always_ff @(posedge clk) begin
    term <= TERM_W'(mul_a) * TERM_W'(mul_a);
  end

  // Point store: one write port for loads, one registered read port for queries.
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      mem[fill_addr[IDX_W-1:0]] <= pt_reg[0];
    end
    rd_data <= mem[rd_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < UDIMS; i++) begin
        pt_reg[i] <= in_coord[i];
      end
    end else if (rotate) begin
      for (int i = 0; i < UDIMS; i++) begin
        pt_reg[i] <= pt_reg[(i == UDIMS - 1) ? 0 : i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  // Read and multiply stage tags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
    s1_last_dim <= last_dim;
    s1_last     <= (rd_addr == ADDR_W'(fill_addr - ADDR_W'(1)));
    s2_last_dim <= s1_last_dim;
    s2_last     <= s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      fill_addr     <= '0;
      rd_addr       <= '0;
      dim_cnt       <= '0;
      sticky_hit    <= 1'b0;
      overflow_flag <= 1'b0;
      qhit          <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            qhit    <= 1'b0;
            dim_cnt <= '0;
            case (cmd.req_type)
              REQ_CLEAR: begin
                count         <= '0;
                fill_addr     <= '0;
                sticky_hit    <= 1'b0;
                overflow_flag <= 1'b0;
                state         <= S_DONE;
              end
              REQ_LOAD: begin
                if (count == CNT_W'(MAX_POINTS)) begin
                  overflow_flag <= 1'b1;
                  state         <= S_DONE;
                end else begin
                  state <= S_LOAD;
                end
              end
              REQ_QUERY: begin
                state <= S_LIM;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_LOAD: begin
          fill_addr <= fill_addr + ADDR_W'(1);
          dim_cnt   <= dim_cnt + DIM_W'(1);
          if (last_dim) begin
            count <= count + CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_LIM: begin
          state <= S_LIM2;
        end
        S_LIM2: begin
          lim     <= term;
          acc     <= '0;
          rd_addr <= '0;
          dim_cnt <= '0;
          state   <= (fill_addr == '0) ? S_DONE : S_RUN;
        end
        S_RUN: begin
          if (issue) begin
            rd_addr <= rd_addr + ADDR_W'(1);
            dim_cnt <= last_dim ? '0 : dim_cnt + DIM_W'(1);
          end
          if (s2_valid) begin
            if (s2_last_dim) begin
              acc <= '0;
              if (sum_next < SUM_W'(lim)) begin
                qhit       <= 1'b1;
                sticky_hit <= 1'b1;
              end
            end else begin
              acc <= sum_next;
            end
            if (s2_last) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign count32 = 32'(count);

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      result.point_hit    <= qhit;
      result.any_hit      <= sticky_hit;
      result.stored_count <= count32[COUNT_BITS-1:0];
      result.overflow     <= overflow_flag;
    end
  end

endmodule

// ===== bench/all_pairs_proximity_test_7d_tb.sv =====
// Self-checking testbench for the all-pairs proximity test block: drives command
// words and threshold writes, predicts every result word and compares it.
// Depends on apt_pkg and all_pairs_proximity_test_7d.
module all_pairs_proximity_test_7d_tb;
  import apt_pkg::*;

  localparam int STORE_DEPTH = 256;
  localparam int DIMS = 7;
  localparam int RANDOM_WORDS = 1300;
  localparam int IDLE_PCT = 37;
  localparam int CYCLE_LIMIT = 16000000;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef logic [DIMS-1:0][COORD_BITS-1:0] point_t;

  typedef struct {
    bit          is_cfg;
    logic [15:0] cfg_value;
    apt_cmd_t    word;
    bit          typed;
    apt_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  apt_cmd_t    cmd;
  logic        done;
  apt_result_t result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // Shadow copy of the block's state, updated as each word is accepted.
  point_t      shadow_pts [STORE_DEPTH];
  int unsigned shadow_count;
  bit          shadow_sticky;
  bit          shadow_ovf;
  logic [15:0] shadow_thr;

  apt_result_t pending_status [$];
  stim_row_t   stim_rows [$];
  int          bad_words = 0;
  int          cycle_count = 0;
  int          words_sent = 0;
  int          idle_pct = IDLE_PCT;
  bit          start_up = 1'b0;

  all_pairs_proximity_test_7d #(
    .MAX_POINTS(STORE_DEPTH),
    .DIMENSIONS(DIMS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL all_pairs_proximity_test_7d");
      $finish;
    end
  end

  function automatic point_t coords_of(apt_cmd_t w);
    point_t p;
    p[0] = w.coord_0;
    p[1] = w.coord_1;
    p[2] = w.coord_2;
    p[3] = w.coord_3;
    p[4] = w.coord_4;
    p[5] = w.coord_5;
    p[6] = w.coord_6;
    return p;
  endfunction

  function automatic apt_cmd_t pack_word(logic [1:0] req, point_t p);
    apt_cmd_t w;
    w.req_type = req;
    w.coord_0 = p[0];
    w.coord_1 = p[1];
    w.coord_2 = p[2];
    w.coord_3 = p[3];
    w.coord_4 = p[4];
    w.coord_5 = p[5];
    w.coord_6 = p[6];
    return w;
  endfunction

  function automatic point_t flat(logic [15:0] v);
    point_t p;
    for (int d = 0; d < DIMS; d++) p[d] = v;
    return p;
  endfunction

  // Exact squared distance in Q16.16; at most 7 * 65535^2, far inside 64 bits.
  function automatic longint dist_sq(point_t a, point_t b);
    longint acc;
    longint diff;
    acc = 0;
    for (int d = 0; d < DIMS; d++) begin
      diff = longint'($signed(a[d])) - longint'($signed(b[d]));
      acc += diff * diff;
    end
    return acc;
  endfunction

  function automatic apt_result_t proximity_step(apt_cmd_t w);
    point_t      p;
    longint      lim;
    bit          hit;
    apt_result_t r;
    p = coords_of(w);
    hit = 1'b0;
    lim = longint'(shadow_thr) * longint'(shadow_thr);
    case (w.req_type)
      REQ_CLEAR: begin
        shadow_count = 0;
        shadow_sticky = 1'b0;
        shadow_ovf = 1'b0;
      end
      REQ_LOAD: begin
        if (shadow_count >= STORE_DEPTH) begin
          shadow_ovf = 1'b1;
        end else begin
          shadow_pts[shadow_count] = p;
          shadow_count++;
        end
      end
      REQ_QUERY: begin
        for (int i = 0; i < shadow_count; i++)
          if (dist_sq(shadow_pts[i], p) < lim) hit = 1'b1;
        if (hit) shadow_sticky = 1'b1;
      end
      default: ;
    endcase
    r.point_hit = hit;
    r.any_hit = shadow_sticky;
    r.stored_count = shadow_count[COUNT_BITS-1:0];
    r.overflow = shadow_ovf;
    return r;
  endfunction

  function automatic apt_result_t status_of(bit hit, bit any, int count, bit ovf);
    apt_result_t r;
    r.point_hit = hit;
    r.any_hit = any;
    r.stored_count = count[COUNT_BITS-1:0];
    r.overflow = ovf;
    return r;
  endfunction

  function automatic stim_row_t word_row(logic [1:0] req, point_t p);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.cfg_value = '0;
    row.word = pack_word(req, p);
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic stim_row_t known_row(logic [1:0] req, point_t p, apt_result_t want);
    stim_row_t row;
    row = word_row(req, p);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [15:0] v);
    stim_row_t row;
    row = word_row(REQ_UNUSED, '0);
    row.is_cfg = 1'b1;
    row.cfg_value = v;
    return row;
  endfunction

  function automatic void add_row(stim_row_t row);
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  // A spread above 32767 gives a point anywhere in the coordinate range.
  function automatic point_t rand_point(point_t ctr, int spread);
    point_t p;
    int     off;
    for (int d = 0; d < DIMS; d++) begin
      if (spread > 32767) begin
        p[d] = 16'($urandom);
      end else begin
        off = int'($urandom_range(0, 2 * spread)) - spread;
        p[d] = ctr[d] + off[15:0];
      end
    end
    return p;
  endfunction

  function automatic logic [15:0] pick_threshold();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3, 4, 5: return 16'($urandom_range(16, 1023));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic check_field(string name, logic [8:0] want, logic [8:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      bad_words++;
    end
  endtask

  always @(posedge clk) begin : check_results
    apt_result_t want;
    if (!rst && done) begin
      if (pending_status.size() == 0) begin
        $error("result word with no word outstanding");
        bad_words++;
      end else begin
        want = pending_status.pop_front();
        check_field("point_hit", want.point_hit, result.point_hit);
        check_field("any_hit", want.any_hit, result.any_hit);
        check_field("stored_count", want.stored_count, result.stored_count);
        check_field("overflow", want.overflow, result.overflow);
      end
    end
  end

  task automatic pause_start(int n);
    if (start_up) begin
      start <= 1'b0;
      start_up = 1'b0;
    end
    repeat (n) @(posedge clk);
  endtask

  task automatic send_word(apt_cmd_t w, bit typed = 1'b0, apt_result_t typed_want = '0);
    apt_result_t want;
    if (!start_up) begin
      start <= 1'b1;
      start_up = 1'b1;
    end
    cmd <= w;
    do @(posedge clk); while (busy !== 1'b0);
    want = proximity_step(w);
    pending_status.insert(pending_status.size(), typed ? typed_want : want);
    if (w.req_type != REQ_UNUSED) words_sent++;
    if ($urandom_range(99) < idle_pct) pause_start($urandom_range(1, 9));
  endtask

  task automatic drain_results();
    pause_start(0);
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(logic [15:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    shadow_thr = v;
  endtask

  // Fills the store to the brim, loads once more so the word is dropped, then queries and clears.
  task automatic fill_store();
    point_t ctr;
    ctr = rand_point('0, 32768);
    set_threshold(16'd1024);
    send_word(pack_word(REQ_CLEAR, ctr));
    repeat (STORE_DEPTH) send_word(pack_word(REQ_LOAD, rand_point(ctr, 4096)));
    send_word(pack_word(REQ_LOAD, ctr));
    send_word(pack_word(REQ_QUERY, rand_point(shadow_pts[STORE_DEPTH-1], 256)));
    send_word(pack_word(REQ_QUERY, shadow_pts[STORE_DEPTH-1]));
    send_word(pack_word(REQ_QUERY, rand_point(ctr, 32768)));
    send_word(pack_word(REQ_UNUSED, ctr));
    send_word(pack_word(REQ_CLEAR, ctr));
  endtask

  // One phase: maybe a new threshold, usually a clear, a few loads, then a run of
  // words, mostly queries near stored points, so hits and near misses both occur.
  task automatic run_phase();
    point_t ctr;
    int     spread;
    int     near_spread;
    int     loads;
    int     queries;
    int     pick;
    int     idx;
    if ($urandom_range(1) == 1) set_threshold(pick_threshold());
    ctr = rand_point('0, 32768);
    case ($urandom_range(3))
      0: spread = 32768;
      1: spread = 64;
      2: spread = 2048;
      default: spread = int'(shadow_thr) + 1;
    endcase
    near_spread = int'(shadow_thr) / 2 + 1;
    if (shadow_count > 24 || $urandom_range(99) < 85)
      send_word(pack_word(REQ_CLEAR, rand_point(ctr, spread)));
    loads = ($urandom_range(3) == 0) ? $urandom_range(9, 32) : $urandom_range(0, 8);
    repeat (loads) send_word(pack_word(REQ_LOAD, rand_point(ctr, spread)));
    queries = $urandom_range(2, 16);
    repeat (queries) begin
      pick = $urandom_range(99);
      idx = (shadow_count == 0) ? 0 : $urandom_range(shadow_count - 1);
      if (shadow_count != 0 && pick < 55)
        send_word(pack_word(REQ_QUERY, rand_point(shadow_pts[idx], near_spread)));
      else if (shadow_count != 0 && pick < 65)
        send_word(pack_word(REQ_QUERY, shadow_pts[idx]));
      else if (pick < 85)
        send_word(pack_word(REQ_QUERY, rand_point(ctr, spread)));
      else if (pick < 92)
        send_word(pack_word(REQ_UNUSED, rand_point(ctr, 32768)));
      else if (pick < 97 && shadow_count < 48)
        send_word(pack_word(REQ_LOAD, rand_point(ctr, spread)));
      else
        send_word(pack_word(REQ_CLEAR, rand_point(ctr, 32768)));
    end
  endtask

  initial begin : stimulus
    point_t    p;
    point_t    q;
    int        base;
    bit        mid_fill_done;
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    shadow_count = 0;
    shadow_sticky = 1'b0;
    shadow_ovf = 1'b0;
    shadow_thr = '0;
    mid_fill_done = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed rows; the threshold is still zero after reset.
    add_row(known_row(REQ_QUERY, flat(16'h0000), status_of(1'b0, 1'b0, 0, 1'b0)));
    add_row(known_row(REQ_UNUSED, flat(16'h5A5A), status_of(1'b0, 1'b0, 0, 1'b0)));
    add_row(known_row(REQ_CLEAR, flat(16'hA5A5), status_of(1'b0, 1'b0, 0, 1'b0)));
    add_row(known_row(REQ_LOAD, flat(16'h7FFF), status_of(1'b0, 1'b0, 1, 1'b0)));
    // With a zero threshold even an exact match is not strictly below it.
    add_row(known_row(REQ_QUERY, flat(16'h7FFF), status_of(1'b0, 1'b0, 1, 1'b0)));
    add_row(cfg_row(16'd1));
    add_row(known_row(REQ_QUERY, flat(16'h7FFF), status_of(1'b1, 1'b1, 1, 1'b0)));
    add_row(known_row(REQ_LOAD, flat(16'h8000), status_of(1'b0, 1'b1, 2, 1'b0)));
    add_row(cfg_row(16'hFFFF));
    add_row(word_row(REQ_QUERY, flat(16'h0000)));
    // One axis off by exactly the threshold: equal, so not a hit.
    q = flat(16'h7FFF);
    q[0] = 16'h8000;
    add_row(word_row(REQ_QUERY, q));
    q = flat(16'h8000);
    q[6] = 16'h7F00;
    add_row(word_row(REQ_QUERY, q));
    add_row(known_row(REQ_CLEAR, flat(16'h0001), status_of(1'b0, 1'b0, 0, 1'b0)));
    // The clear keeps the wide threshold, but an empty store never hits.
    add_row(known_row(REQ_QUERY, flat(16'h8000), status_of(1'b0, 1'b0, 0, 1'b0)));
    p = rand_point('0, 32768);
    add_row(word_row(REQ_LOAD, p));
    add_row(word_row(REQ_LOAD, rand_point(p, 300)));
    add_row(word_row(REQ_QUERY, rand_point(p, 100)));
    add_row(word_row(REQ_UNUSED, flat(16'hFFFF)));
    add_row(cfg_row(16'd0));
    add_row(word_row(REQ_QUERY, p));
    add_row(cfg_row(16'd300));
    add_row(word_row(REQ_QUERY, rand_point(p, 128)));
    add_row(word_row(REQ_LOAD, flat(16'hFFFF)));
    add_row(known_row(REQ_CLEAR, p, status_of(1'b0, 1'b0, 0, 1'b0)));

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) set_threshold(stim_rows[i].cfg_value);
      else send_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].want);
    end
    fill_store();

    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      // A long stretch in the middle runs with the sender never idling.
      idle_pct = (words_sent - base >= 600 && words_sent - base < 950) ? 0 : IDLE_PCT;
      if (!mid_fill_done && words_sent - base >= RANDOM_WORDS / 2) begin
        fill_store();
        mid_fill_done = 1'b1;
      end
      run_phase();
    end

    drain_results();
    if (bad_words == 0) begin
      $display("PASS all_pairs_proximity_test_7d");
    end else begin
      $display("FAIL all_pairs_proximity_test_7d");
    end
    $finish;
  end

endmodule
